// ----- rtl/core/kwm_pkg.sv -----
`default_nettype none

package kwm_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME_RD,
    ST_PRIME_WR,
    ST_SCAN,
    ST_EMIT,
    ST_REFILL
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_we;
    logic prime_rd;
    logic prime_wr;
    logic scan_en;
    logic take;
    logic refill_wr;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic load_last;
    logic prime_last;
    logic scan_last;
    logic out_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/kwm_ctrl.sv -----
`default_nettype none

module kwm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          out_ready,
  input  wire kwm_pkg::sts_t sts,
  output logic               in_ready,
  output logic               out_valid,
  output kwm_pkg::cmd_t      cmd
);

  kwm_pkg::state_t state;
  kwm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kwm_pkg::ST_LOAD: begin
        if (in_valid && sts.load_last) state_next = kwm_pkg::ST_PRIME_RD;
      end
      kwm_pkg::ST_PRIME_RD: begin
        state_next = kwm_pkg::ST_PRIME_WR;
      end
      kwm_pkg::ST_PRIME_WR: begin
        state_next = sts.prime_last ? kwm_pkg::ST_SCAN : kwm_pkg::ST_PRIME_RD;
      end
      kwm_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = kwm_pkg::ST_EMIT;
      end
      kwm_pkg::ST_EMIT: begin
        if (out_ready) state_next = sts.out_last ? kwm_pkg::ST_LOAD : kwm_pkg::ST_REFILL;
      end
      kwm_pkg::ST_REFILL: begin
        state_next = kwm_pkg::ST_SCAN;
      end
      default: begin
        state_next = kwm_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state == kwm_pkg::ST_LOAD);
    out_valid     = (state == kwm_pkg::ST_EMIT);
    cmd.load_we   = (state == kwm_pkg::ST_LOAD) && in_valid;
    cmd.prime_rd  = (state == kwm_pkg::ST_PRIME_RD);
    cmd.prime_wr  = (state == kwm_pkg::ST_PRIME_WR);
    cmd.scan_en   = (state == kwm_pkg::ST_SCAN);
    cmd.take      = (state == kwm_pkg::ST_EMIT) && out_ready;
    cmd.refill_wr = (state == kwm_pkg::ST_REFILL);
  end

endmodule

`default_nettype wire

// ----- rtl/core/kwm_datapath.sv -----
`default_nettype none

module kwm_datapath #(
  parameter int NUM_WAYS = 4,
  parameter int RUN_LEN  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kwm_pkg::cmd_t cmd,
  input  wire logic [31:0]   value,
  output kwm_pkg::sts_t      sts,
  output logic [31:0]        merged_value,
  output logic               final_word
);

  localparam int TOTAL = NUM_WAYS * RUN_LEN;
  localparam int AW    = $clog2(TOTAL);
  localparam int WW    = $clog2(NUM_WAYS);
  localparam int HW    = $clog2(RUN_LEN + 1);

  logic [31:0]   mem [TOTAL];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic [AW-1:0] load_count;
  logic [AW-1:0] out_count;
  logic [WW-1:0] pcnt;
  logic [WW-1:0] scan_idx;
  logic [HW-1:0] head [NUM_WAYS];
  logic [31:0]   cache [NUM_WAYS];

  logic          found;
  logic [WW-1:0] best_way;
  logic [31:0]   best_val;

  logic          pick;
  logic [31:0]   best_val_next;
  logic [WW-1:0] best_way_next;
  logic [HW-1:0] head_inc;

  assign sts.load_last  = (load_count == AW'(TOTAL - 1));
  assign sts.prime_last = (pcnt == WW'(NUM_WAYS - 1));
  assign sts.scan_last  = (scan_idx == WW'(NUM_WAYS - 1));
  assign sts.out_last   = (out_count == AW'(TOTAL - 1));

  // one compare per cycle against the running minimum; strict less keeps the lower way
  always_comb begin
    pick = (head[scan_idx] != HW'(RUN_LEN)) &&
           (!(found && (scan_idx != '0)) || (cache[scan_idx] < best_val));
    best_val_next = pick ? cache[scan_idx] : best_val;
    best_way_next = pick ? scan_idx : best_way;
  end

  assign head_inc = head[best_way] + HW'(1);

  // read port address: way base plus the next head index, or the way base alone when priming
  always_comb begin
    if (cmd.prime_rd) begin
      rd_addr = AW'(AW'(pcnt) * AW'(RUN_LEN));
      rd_en   = 1'b1;
    end else begin
      rd_addr = AW'(AW'(best_way) * AW'(RUN_LEN)) + AW'(head_inc);
      rd_en   = cmd.take && (head_inc != HW'(RUN_LEN));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we) mem[load_count] <= value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      out_count  <= '0;
      pcnt       <= '0;
      scan_idx   <= '0;
      found      <= 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) head[w] <= '0;
    end else begin
      if (cmd.load_we) begin
        load_count <= sts.load_last ? '0 : load_count + AW'(1);
      end
      if (cmd.prime_wr) begin
        pcnt <= sts.prime_last ? '0 : pcnt + WW'(1);
      end
      if (cmd.scan_en) begin
        scan_idx <= sts.scan_last ? '0 : scan_idx + WW'(1);
        // each scan starts with no candidate
        found    <= sts.scan_last ? 1'b0 : (found || pick);
      end
      if (cmd.take) begin
        if (sts.out_last) begin
          out_count <= '0;
          for (int w = 0; w < NUM_WAYS; w++) head[w] <= '0;
        end else begin
          out_count      <= out_count + AW'(1);
          head[best_way] <= head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prime_wr) cache[pcnt] <= rd_data;
    if (cmd.refill_wr) cache[best_way] <= rd_data;
    if (cmd.scan_en) begin
      best_val <= best_val_next;
      best_way <= best_way_next;
      if (sts.scan_last) begin
        merged_value <= best_val_next;
        final_word   <= sts.out_last;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/k_way_sorted_merge_unit.sv -----
// k-way merge of sorted runs
//
// input channel (in_valid/in_ready/value): one 32-bit word per transaction.
// the first RUN_LEN words form run 0, the next RUN_LEN words run 1, and so on,
// NUM_WAYS runs in total.
// after the last word the block merges the runs and emits all NUM_WAYS*RUN_LEN
// words on the output channel (out_valid/out_ready/merged_value/final_word),
// smallest head first, lowest run index on a tie; final_word marks the last one.
// the merge first primes the run heads with a read state and a write state per
// way, then for each output word it scans the cached heads, emits the result
// and, but for the last word, refills the head of the way that was taken.
// the scan uses a single comparator over the cached run heads, one way per
// cycle, and the refill waits on the one registered read port of the store.
// in_ready is high only during loading; no input is taken during a merge.
// when the receiver stalls, the result register holds its word and the merge
// waits. reset returns the block to loading with all counters and heads at zero;
// the word store itself is not cleared, every entry is rewritten before use.
`default_nettype none

module k_way_sorted_merge_unit #(
  parameter int NUM_WAYS = 4,
  parameter int RUN_LEN  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      merged_value,
  output logic             final_word
);

  // command and status between controller and datapath
  kwm_pkg::cmd_t cmd;
  kwm_pkg::sts_t sts;

  kwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  kwm_datapath #(
    .NUM_WAYS (NUM_WAYS),
    .RUN_LEN  (RUN_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .sts          (sts),
    .merged_value (merged_value),
    .final_word   (final_word)
  );

`ifndef SYNTHESIS
  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // after the last merged word the block is back to loading
  a_final_reload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && final_word) |=> in_ready)
    else $error("no return to loading after final word");

  // an input transaction is never directly followed by a result
  a_load_no_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result right after an input word");
`endif

endmodule

`default_nettype wire

// ----- bench/merge_checker.sv -----
`default_nettype none

module merge_checker #(
  parameter int NUM_WAYS = 4,
  parameter int RUN_LEN  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] merged_value,
  input  wire logic        final_word,
  output int               fail_count,
  output int               words_pending
);

  localparam int TOTAL_WORDS = NUM_WAYS * RUN_LEN;

  typedef struct packed {
    logic [31:0] merged_value;
    logic        final_word;
  } merged_word_t;

  logic [31:0]  batch_words [TOTAL_WORDS];
  int           words_loaded;
  int           mismatches;
  merged_word_t merged_words_q [$];
  merged_word_t want;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_loaded  = 0;
    mismatches    = 0;
  end

  // smallest live head each round, lowest way on a tie
  task automatic predict_merge();
    int           head [NUM_WAYS];
    int           pick;
    logic [31:0]  low_word;
    merged_word_t item;
    for (int w = 0; w < NUM_WAYS; w++) head[w] = 0;
    low_word = '0;
    for (int k = 0; k < TOTAL_WORDS; k++) begin
      pick = -1;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (head[w] < RUN_LEN) begin
          if (pick < 0 || batch_words[w * RUN_LEN + head[w]] < low_word) begin
            pick     = w;
            low_word = batch_words[w * RUN_LEN + head[w]];
          end
        end
      end
      head[pick]++;
      item.merged_value = low_word;
      item.final_word   = (k == TOTAL_WORDS - 1);
      merged_words_q.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      words_loaded = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (merged_words_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %h final %b",
                   $time, merged_value, final_word);
          mismatches++;
        end else begin
          want = merged_words_q.pop_front();
          if (merged_value !== want.merged_value) begin
            $display("%0t: merged_value mismatch, expected %h, got %h",
                     $time, want.merged_value, merged_value);
            mismatches++;
          end
          if (final_word !== want.final_word) begin
            $display("%0t: final_word mismatch, expected %b, got %b",
                     $time, want.final_word, final_word);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        batch_words[words_loaded] = value;
        words_loaded++;
        if (words_loaded == TOTAL_WORDS) begin
          predict_merge();
          words_loaded = 0;
        end
      end
    end
    fail_count    <= mismatches;
    words_pending <= merged_words_q.size();
  end

endmodule

`default_nettype wire

// ----- bench/tb_k_way_sorted_merge_unit.sv -----
`default_nettype none

module tb_k_way_sorted_merge_unit;

  localparam int NUM_WAYS    = 4;
  localparam int RUN_LEN     = 16;
  localparam int TOTAL_WORDS = NUM_WAYS * RUN_LEN;

  // five batches in all: one hand-built, the rest random
  localparam int RANDOM_BATCHES = 4;

  // receiver goes quiet for a long stretch partway into the second merge
  localparam int HOLD_AT     = TOTAL_WORDS + 10;
  localparam int HOLD_CYCLES = 600;

  // no transaction for this long means the block is hung; the long hold,
  // the head priming and a full scan per word all fit well inside it
  localparam int STALL_LIMIT = 4000;

  // after the last word is out, a few merge steps of quiet time
  localparam int DRAIN_CYCLES = 4 * (NUM_WAYS + 2);

  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [31:0] value     = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] merged_value;
  logic        final_word;
  int          fail_count;
  int          words_pending;

  // words of the batch being sent, run 0 first
  logic [31:0] batch_buf [TOTAL_WORDS];
  // transactions left in the current sender burst
  int          burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  k_way_sorted_merge_unit #(
    .NUM_WAYS(NUM_WAYS),
    .RUN_LEN (RUN_LEN)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .merged_value(merged_value),
    .final_word  (final_word)
  );

  merge_checker #(
    .NUM_WAYS(NUM_WAYS),
    .RUN_LEN (RUN_LEN)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .merged_value (merged_value),
    .final_word   (final_word),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  // hand-built batch covering the corner cases of the merge:
  //   run 0 counts up from a repeated zero and is used up after run 3
  //   run 1 is all ones, top of the word range, and drains last
  //   run 2 counts down, so the run is out of order
  //   run 3 repeats small words that tie with run 0 and with itself
  task automatic fill_directed_batch();
    for (int i = 0; i < RUN_LEN; i++) begin
      batch_buf[i]               = (i == 0) ? 32'h0 : 32'(i - 1);
      batch_buf[RUN_LEN + i]     = 32'hFFFF_FFFF;
      batch_buf[2 * RUN_LEN + i] = 32'hFFFF_FFFE - 32'(i);
      batch_buf[3 * RUN_LEN + i] = 32'(i >> 1);
    end
  endtask

  // ascending order within one run
  task automatic sort_run(input int first);
    logic [31:0] key;
    int          j;
    for (int i = first + 1; i < first + RUN_LEN; i++) begin
      key = batch_buf[i];
      j   = i - 1;
      while (j >= first && batch_buf[j] > key) begin
        batch_buf[j + 1] = batch_buf[j];
        j--;
      end
      batch_buf[j + 1] = key;
    end
  endtask

  // mostly sorted runs with random content; some runs crowd the bottom or
  // the top of the range to force ties, some are flat, a few are unsorted
  task automatic fill_random_batch();
    int          kind;
    int          first;
    logic [31:0] flat_word;
    for (int w = 0; w < NUM_WAYS; w++) begin
      kind      = $urandom_range(0, 9);
      first     = w * RUN_LEN;
      flat_word = $urandom;
      for (int i = 0; i < RUN_LEN; i++) begin
        case (kind)
          6: batch_buf[first + i] = 32'($urandom_range(0, 3));
          7: batch_buf[first + i] = 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
          8: batch_buf[first + i] = flat_word;
          default: batch_buf[first + i] = $urandom;
        endcase
      end
      // kind 9 stays unsorted on purpose
      if (kind != 8 && kind != 9) sort_run(first);
    end
  endtask

  // one input transaction; bursts of random length with random gaps,
  // now and then a long burst with no gap at all
  task automatic offer_word(input logic [31:0] word);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    value    <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_batch();
    for (int i = 0; i < TOTAL_WORDS; i++) offer_word(batch_buf[i]);
  endtask

  // stop offering and let every merged word come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    fill_directed_batch();
    offer_batch();

    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      fill_random_batch();
      offer_batch();
      // the third batch is followed by a full drain before the next one;
      // it is offered while the receiver holds off the second merge
      if (b == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: segments of random length, each with its own ready pattern,
  // and one long hold-off while the sender keeps pushing the next batch
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       phase;
    int       taken;
    bit       held;
    mode     = RX_FREE;
    seg_left = 0;
    phase    = 0;
    taken    = 0;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) taken++;
      if (!held && taken >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 100);
        end
        seg_left--;
        phase++;
        case (mode)
          RX_FREE:        out_ready <= 1'b1;
          RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
          RX_ONE_IN_FOUR: out_ready <= (phase % 4 == 0);
          default:        out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // watchdog on transaction progress
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/kwm_pkg.sv
rtl/core/kwm_ctrl.sv
rtl/core/kwm_datapath.sv
rtl/core/k_way_sorted_merge_unit.sv
bench/merge_checker.sv
bench/tb_k_way_sorted_merge_unit.sv
